/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files; bht_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, held off while reset is asserted.
`define BHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property at each rising edge, reset included.
`define BHT_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/bht_pkg.sv */
`timescale 1ns / 1ps

package bht_pkg;

    localparam int BUCKETS = 4096;
    localparam int WAYS    = 3;
    localparam int ROW_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NB_W    = 13;
    localparam int PROD_W  = 32 + NB_W;
    localparam int AGE_W   = 5;

    localparam logic [NB_W-1:0] NB_RESET    = NB_W'(4096);
    localparam logic [1:0]      EXACT_RESET = 2'd3;

    typedef enum logic [1:0] {
        REQ_PROBE = 2'd0,
        REQ_STORE = 2'd1,
        REQ_AGE   = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req_e;

    typedef enum logic [0:0] {
        CFG_NUM_BUCKETS = 1'b0,
        CFG_EXACT_BOUND = 1'b1
    } t_cfg_e;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_READ,
        S_EXEC,
        S_WIPE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0]  flag;
        logic [7:0]  depth;
        logic [31:0] se;
        logic [15:0] move;
        logic [15:0] tag;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    typedef struct packed {
        t_req_e       req_type;
        logic [63:0]  hash_key;
        logic [15:0]  entry_move;
        logic [15:0]  entry_score;
        logic [15:0]  entry_eval;
        logic [1:0]   entry_bound;
        logic [7:0]   entry_depth;
        logic         in_pv;
        logic         was_pv;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [15:0] move;
        logic [15:0] score;
        logic [15:0] eval;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic        was_pv;
        logic [4:0]  age;
    } t_result;

    typedef struct packed {
        logic load;
        logic mul;
        logic addr;
        logic read;
        logic exec;
        logic clr_step;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/bht_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bht_ctrl
    import bht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic [1:0] i_req_type,
    input  t_status    i_status,
    output logic       o_s_tready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_req_e'(i_req_type))
                        REQ_PROBE, REQ_STORE: n_state = S_MUL;
                        REQ_AGE:              n_state = S_EXEC;
                        REQ_CLEAR:            n_state = S_WIPE;
                    endcase
                end
            end
            S_MUL:  n_state = S_ADDR;
            S_ADDR: n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_WIPE: begin
                if (i_status.clr_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            S_INIT: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_MUL:  o_cmd.mul  = 1'b1;
            S_ADDR: o_cmd.addr = 1'b1;
            S_READ: o_cmd.read = 1'b1;
            S_EXEC: o_cmd.exec = 1'b1;
            S_WIPE: o_cmd.clr_step = 1'b1;
            S_DONE: o_cmd.push = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    `BHT_ASSERT(a_exec_then_done, i_clk, i_rst_n,
        (r_state == S_EXEC) |=> (r_state == S_DONE), "exec not followed by done")
    `BHT_ASSERT(a_load_leaves_idle, i_clk, i_rst_n,
        o_cmd.load |=> (r_state != S_IDLE), "accepted item left block idle")
    `BHT_ASSERT(a_wipe_ends_done, i_clk, i_rst_n,
        ((r_state == S_WIPE) && i_status.clr_last) |=> (r_state == S_DONE),
        "clear pass did not reply")

endmodule

/* hw/rtl/bht_datapath.sv */
`timescale 1ns / 1ps

module bht_datapath
    import bht_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  t_req            i_req,
    input  logic            i_cfg_we,
    input  logic [0:0]      i_cfg_index,
    input  logic [NB_W-1:0] i_cfg_data,
    input  logic            i_out_ready,
    output t_status         o_status,
    output logic            o_out_valid,
    output t_result         o_out
);

    t_row r_mem [BUCKETS];

    logic [NB_W-1:0]   r_num_buckets;
    logic [1:0]        r_exact;
    logic [AGE_W-1:0]  r_age;
    t_req              r_req;
    logic [PROD_W-1:0] r_plo;
    logic [PROD_W-1:0] r_phi;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_clr;
    t_row              r_rdata;
    t_result           r_res;
    t_result           r_out;
    logic              r_out_valid;

    logic [NB_W-1:0]   w_n;
    logic [PROD_W:0]   w_sum;
    logic [ROW_W-1:0]  w_idx;
    logic [15:0]       w_tag;
    logic [WAY_W-1:0]  w_pick;
    logic              w_pick_found;
    logic [WAY_W-1:0]  w_sel;
    logic              w_hit;
    logic signed [9:0] w_worth [WAYS];
    t_entry            w_old;
    t_entry            w_new;
    t_entry            w_rep;
    t_row              w_wrow;
    logic              w_tag_eq;
    logic              w_we;
    logic [ROW_W-1:0]  w_waddr;
    t_row              w_wdata;

    always_comb begin
        w_n = r_num_buckets;
        if (r_num_buckets == '0) w_n = NB_W'(1);
        else if (r_num_buckets > NB_W'(BUCKETS)) w_n = NB_W'(BUCKETS);
    end

    assign w_sum = {1'b0, r_phi} + (PROD_W + 1)'(r_plo[PROD_W-1:32]);

    always_comb begin
        if (w_sum[PROD_W:32] > (PROD_W - 31)'(BUCKETS - 1)) w_idx = ROW_W'(BUCKETS - 1);
        else w_idx = w_sum[32 +: ROW_W];
    end

    assign w_tag = r_req.hash_key[15:0];

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_worth[i] = $signed({2'b00, r_rdata[i].depth})
                - $signed({3'b000, 5'(r_age - r_rdata[i].flag[7:3]), 2'b00});
        end
    end

    always_comb begin
        w_pick       = '0;
        w_pick_found = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
            if (!w_pick_found) begin
                if (r_rdata[i].tag == w_tag) begin
                    w_pick       = WAY_W'(i);
                    w_pick_found = 1'b1;
                end else if (w_worth[w_pick] > w_worth[i]) begin
                    w_pick = WAY_W'(i);
                end
            end
        end
    end

    always_comb begin
        w_sel = WAY_W'(WAYS - 1);
        w_hit = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_rdata[i].tag == w_tag) begin
                w_sel = WAY_W'(i);
                w_hit = 1'b1;
            end
        end
    end

    assign w_old    = r_rdata[w_pick];
    assign w_tag_eq = (w_old.tag == w_tag);
    assign w_rep    = r_rdata[w_sel];

    always_comb begin
        w_new = w_old;
        if ((r_req.entry_move != '0) || !w_tag_eq) w_new.move = r_req.entry_move;
        if ((r_req.entry_bound == r_exact) || !w_tag_eq
            || (({2'b00, r_req.entry_depth} + 10'd5 + {8'd0, r_req.in_pv, 1'b0})
                > {2'b00, w_old.depth})
            || (w_old.flag[7:3] != r_age)) begin
            w_new.tag   = w_tag;
            w_new.flag  = {r_age, r_req.was_pv, r_req.entry_bound};
            w_new.se    = {r_req.entry_score, r_req.entry_eval};
            w_new.depth = r_req.entry_depth;
        end
        w_wrow         = r_rdata;
        w_wrow[w_pick] = w_new;
    end

    assign w_we    = i_cmd.clr_step || (i_cmd.exec && (r_req.req_type == REQ_STORE));
    assign w_waddr = i_cmd.clr_step ? r_clr : r_row;
    assign w_wdata = i_cmd.clr_step ? t_row'('0) : w_wrow;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (i_cmd.read) r_rdata <= r_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.mul) begin
            r_plo <= PROD_W'(r_req.hash_key[31:0] * w_n);
            r_phi <= PROD_W'(r_req.hash_key[63:32] * w_n);
        end
        if (i_cmd.addr) r_row <= w_idx;
        if (i_cmd.load) begin
            r_res <= '0;
        end else if (i_cmd.exec && (r_req.req_type == REQ_PROBE)) begin
            r_res.hit    <= w_hit;
            r_res.move   <= w_rep.move;
            r_res.score  <= w_rep.se[31:16];
            r_res.eval   <= w_rep.se[15:0];
            r_res.depth  <= w_rep.depth;
            r_res.bound  <= w_rep.flag[1:0];
            r_res.was_pv <= w_rep.flag[2];
            r_res.age    <= w_rep.flag[7:3];
        end
        if (i_cmd.push) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buckets <= NB_RESET;
            r_exact       <= EXACT_RESET;
            r_age         <= AGE_W'(1);
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_e'(i_cfg_index))
                    CFG_NUM_BUCKETS: r_num_buckets <= i_cfg_data;
                    CFG_EXACT_BOUND: r_exact       <= i_cfg_data[1:0];
                endcase
            end
            if (i_cmd.clr_step) begin
                if (o_status.clr_last) begin
                    r_clr <= '0;
                    r_age <= AGE_W'(1);
                end else begin
                    r_clr <= r_clr + ROW_W'(1);
                end
            end else if (i_cmd.exec && (r_req.req_type == REQ_AGE)) begin
                r_age <= r_age + AGE_W'(1);
            end
            if (i_cmd.push) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_status.clr_last = (r_clr == ROW_W'(BUCKETS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

/* hw/rtl/bucketed_hash_table_age_replacement_core.sv */
`timescale 1ns / 1ps
// Probe or store steps through multiply, index, read, update and reply; advance age
// steps through update and reply. One item is handled at a time: no new item is
// taken until its reply has been pushed, and the reply waits while the output is full.
// Clear table walks one bucket row per cycle through the whole table, then replies.
// Reset (synchronous, active low) starts the same clearing pass; no item
// is accepted until it ends. Config writes are taken at any time.
module bucketed_hash_table_age_replacement_core
    import bht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // [63:0] hash_key, [79:64] entry_move, [95:80] entry_score, [111:96] entry_eval,
    // [113:112] entry_bound, [121:114] entry_depth, [122] in_pv, [123] was_pv
    input  logic [127:0]     i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]       i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [15:0] found_move, [31:16] found_score, [47:32] found_eval, [55:48] found_depth,
    // [57:56] found_bound, [58] found_was_pv, [63:59] found_age
    output logic [63:0]      o_m_tdata,
    // [0] hit
    output logic [0:0]       o_m_tuser,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [NB_W-1:0]  i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    t_req    w_req;
    t_result w_out;

    assign w_req.req_type    = t_req_e'(i_s_tuser);
    assign w_req.hash_key    = i_s_tdata[63:0];
    assign w_req.entry_move  = i_s_tdata[79:64];
    assign w_req.entry_score = i_s_tdata[95:80];
    assign w_req.entry_eval  = i_s_tdata[111:96];
    assign w_req.entry_bound = i_s_tdata[113:112];
    assign w_req.entry_depth = i_s_tdata[121:114];
    assign w_req.in_pv       = i_s_tdata[122];
    assign w_req.was_pv      = i_s_tdata[123];

    assign o_cfg_ready = 1'b1;

    bht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req_type (i_s_tuser),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    bht_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (w_req),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_tvalid),
        .o_out       (w_out)
    );

    assign o_m_tdata = {w_out.age, w_out.was_pv, w_out.bound, w_out.depth,
                        w_out.eval, w_out.score, w_out.move};
    assign o_m_tuser = w_out.hit;

endmodule
